>>> hdl/tdfc_pkg.sv
// ----------------------------------------------------------------------------
// tdfc_pkg
// Shared types and constants of the texel decimation / format conversion block.
// ----------------------------------------------------------------------------
`default_nettype none

package tdfc_pkg;

   localparam int SOURCE_SIDE_DEFAULT = 256;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 20;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_FORMAT_MODE    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEVEL_SIZE     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_WIDTHS = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_SHIFTS = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BITS_PER_PIXEL = 3'd4;

   // format modes
   localparam logic [1:0] MODE_CONVERT = 2'd0;
   localparam logic [1:0] MODE_COPY32  = 2'd1;
   localparam logic [1:0] MODE_COPY16  = 2'd2;

   // register reset values
   localparam logic [1:0]  RST_FORMAT_MODE    = MODE_CONVERT;
   localparam logic [3:0]  RST_LEVEL_SIZE     = 4'd8;
   localparam logic [15:0] RST_CHANNEL_WIDTHS = 16'h8888;
   localparam logic [19:0] RST_CHANNEL_SHIFTS = 20'd786704;
   localparam logic [5:0]  RST_BITS_PER_PIXEL = 6'd32;

   typedef struct packed {
      logic [31:0] source_texel;
      logic        page_start;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  format_mode;
      logic [3:0]  level_size_log2;
      logic [15:0] channel_widths;
      logic [19:0] channel_shifts;
      logic [5:0]  bits_per_pixel;
   } cfg_type;

   // one converted pixel waiting for serialization; count is 1 to 4 bytes
   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  count;
   } job_type;

endpackage

`default_nettype wire

>>> hdl/tdfc_front.sv
// ----------------------------------------------------------------------------
// tdfc_front
// Tracks page position, decides whether a texel is kept and converts it.
// ----------------------------------------------------------------------------
`default_nettype none

module tdfc_front import tdfc_pkg::*; #(
   parameter int SOURCE_SIDE = SOURCE_SIDE_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    req_push,
   input  wire req_type req_data,
   output logic         req_full,
   input  wire logic    job_full,
   output logic         job_push,
   output job_type      job
);

   localparam int CW    = $clog2(SOURCE_SIDE);
   localparam int RW    = CW;
   localparam int LANES = $clog2(SOURCE_SIDE);   // levels with side below the page
   localparam int LIW   = $clog2(LANES);
   localparam logic [4:0]    LANES_W  = 5'(LANES);
   localparam logic [CW-1:0] LAST_POS = CW'(SOURCE_SIDE - 1);
   localparam logic [RW:0]   SIDE_W   = (RW+1)'(SOURCE_SIDE);

   logic [CW-1:0] col_ff, col_in, row_ff, row_in, cur_col, cur_row;
   logic          col_wrap, row_wrap, accept, keep;

   // per level: (position << level) mod SOURCE_SIDE
   logic [LANES-1:0][RW-1:0] col_res_ff, col_res_in, ccur, cstep;
   logic [LANES-1:0][RW-1:0] row_res_ff, row_res_in, rcur, rstep;
   logic [LANES-1:0][RW:0]   csum, rsum;
   logic [LANES-1:0]         cpick, rpick;

   logic          all_keep, col_keep, row_keep;
   logic [LIW-1:0] lvl_idx;
   logic [31:0]   packed_word;
   logic [3:0]    bpp_bytes;
   logic [2:0]    count;

   function automatic logic [31:0] pack_channel(input logic [7:0] value,
                                                input logic [3:0] width,
                                                input logic [4:0] shift);
      logic [3:0] w;
      logic [7:0] kept;
      w    = (width > 4'd8) ? 4'd8 : width;
      kept = value >> (4'd8 - w);
      return 32'(kept) << shift;
   endfunction

   assign req_full = job_full;
   assign accept   = req_push && !job_full;

   assign cur_col  = req_data.page_start ? '0 : col_ff;
   assign cur_row  = req_data.page_start ? '0 : row_ff;
   assign col_wrap = (cur_col == LAST_POS);
   assign row_wrap = (cur_row == LAST_POS);
   assign col_in   = col_wrap ? '0 : cur_col + CW'(1);
   assign row_in   = col_wrap ? (row_wrap ? '0 : cur_row + CW'(1)) : cur_row;

   // A source coordinate c is sampled at side 2^l when some multiple of the
   // page side falls in [c*side, c*side + side - 1], i.e. the residue is zero
   // or lies above page side minus level side.
   for (genvar l = 0; l < LANES; l++) begin : g_lane
      localparam logic [RW:0]   STEP   = (RW+1)'(1 << l);
      localparam logic [RW-1:0] THRESH = RW'(SOURCE_SIDE - (1 << l));

      assign ccur[l]  = req_data.page_start ? '0 : col_res_ff[l];
      assign csum[l]  = {1'b0, ccur[l]} + STEP;
      assign cstep[l] = (csum[l] >= SIDE_W) ? RW'(csum[l] - SIDE_W) : csum[l][RW-1:0];
      assign cpick[l] = (ccur[l] == '0) || (ccur[l] > THRESH);

      assign rcur[l]  = req_data.page_start ? '0 : row_res_ff[l];
      assign rsum[l]  = {1'b0, rcur[l]} + STEP;
      assign rstep[l] = (rsum[l] >= SIDE_W) ? RW'(rsum[l] - SIDE_W) : rsum[l][RW-1:0];
      assign rpick[l] = (rcur[l] == '0) || (rcur[l] > THRESH);
   end

   assign col_res_in = col_wrap ? '0 : cstep;
   assign row_res_in = col_wrap ? (row_wrap ? '0 : rstep) : rcur;

   // level side at or above the page side keeps every texel
   assign all_keep = ({1'b0, cfg.level_size_log2} >= LANES_W);
   assign lvl_idx  = cfg.level_size_log2[LIW-1:0];
   assign col_keep = all_keep || cpick[lvl_idx];
   assign row_keep = all_keep || rpick[lvl_idx];
   assign keep     = col_keep && row_keep;

   assign bpp_bytes = 4'(({1'b0, cfg.bits_per_pixel} + 7'd7) >> 3);

   always_comb begin
      packed_word = '0;
      count       = 3'd0;
      unique case (cfg.format_mode)
         MODE_CONVERT: begin
            packed_word = pack_channel(req_data.source_texel[23:16],
                                       cfg.channel_widths[3:0], cfg.channel_shifts[4:0])
                        | pack_channel(req_data.source_texel[15:8],
                                       cfg.channel_widths[7:4], cfg.channel_shifts[9:5])
                        | pack_channel(req_data.source_texel[7:0],
                                       cfg.channel_widths[11:8], cfg.channel_shifts[14:10])
                        | pack_channel(req_data.source_texel[31:24],
                                       cfg.channel_widths[15:12], cfg.channel_shifts[19:15]);
            count = (bpp_bytes > 4'd4) ? 3'd4 : bpp_bytes[2:0];
         end
         MODE_COPY32: begin
            packed_word = req_data.source_texel;
            count       = 3'd4;
         end
         MODE_COPY16: begin
            packed_word = {16'h0000, req_data.source_texel[15:0]};
            count       = 3'd2;
         end
         default: begin
            packed_word = '0;
            count       = 3'd0;
         end
      endcase
   end

   assign job_push   = accept && keep && (count != 3'd0);
   assign job.word   = packed_word;
   assign job.count  = count;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         col_res_ff <= '0;
         row_res_ff <= '0;
      end else if (accept) begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         col_res_ff <= col_res_in;
         row_res_ff <= row_res_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/tdfc_queue.sv
// ----------------------------------------------------------------------------
// tdfc_queue
// Small FIFO of converted pixels between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module tdfc_queue import tdfc_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_data,
   output logic         full,
   input  wire logic    pop,
   output job_type      pop_data,
   output logic         empty
);

   localparam int PW = $clog2(DEPTH);
   localparam int NW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
   localparam logic [NW-1:0] FULL_CNT  = NW'(DEPTH);

   job_type       mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   assign wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + PW'(1);
   assign rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + PW'(1);

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + NW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/tdfc_back.sv
// ----------------------------------------------------------------------------
// tdfc_back
// Serializes queued pixels into bytes, least significant first.
// ----------------------------------------------------------------------------
`default_nettype none

module tdfc_back import tdfc_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    job_empty,
   input  wire job_type job,
   output logic         job_pop,
   input  wire logic    rsp_pop,
   output rsp_type      rsp_data,
   output logic         rsp_empty
);

   logic [31:0] word_ff, word_in;
   logic [2:0]  left_ff, left_in;
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_data_ff, out_data_in;
   logic        out_ready, emit, need_load;

   assign out_ready = !out_valid_ff || rsp_pop;
   assign emit      = out_ready && (left_ff != 3'd0);
   // take the next pixel as the current one drains its last byte
   assign need_load = (left_ff == 3'd0) || (emit && (left_ff == 3'd1));
   assign job_pop   = need_load && !job_empty;

   always_comb begin
      word_in      = word_ff;
      left_in      = left_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (emit) begin
         out_valid_in          = 1'b1;
         out_data_in.out_byte  = word_ff[7:0];
         out_data_in.last_byte = (left_ff == 3'd1);
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
      if (job_pop) begin
         word_in = job.word;
         left_in = job.count;
      end else if (emit) begin
         word_in = word_ff >> 8;
         left_in = left_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      out_data_ff <= out_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff      <= 3'd0;
         out_valid_ff <= 1'b0;
      end else begin
         left_ff      <= left_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_data  = out_data_ff;
   assign rsp_empty = !out_valid_ff;

endmodule

`default_nettype wire

>>> hdl/texel_decimate_format_convert.sv
// ----------------------------------------------------------------------------
// texel_decimate_format_convert
// Keeps the texels of a raster-order source page that nearest-neighbour
// sampling picks for one mip level and emits them as bytes in one of three
// pixel formats.
// ----------------------------------------------------------------------------
// The first byte of a kept request reaches rsp_ by way of the queue write,
//   the serializer load and the output register, in that order.
// Throughput: one request per cycle is accepted while the pixel queue has room;
//   the output side moves one byte per cycle while rsp_pop takes each byte, so a
//   kept request takes 1 to 4 byte slots of the serializer; dropped requests none.
// Reset: synchronous; position returns to the page origin, registers take
//   their defaults, queue and serializer are emptied.
`default_nettype none

module texel_decimate_format_convert import tdfc_pkg::*; #(
   parameter int SOURCE_SIDE = SOURCE_SIDE_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request side
   input  wire logic                   req_push,
   input  wire req_type                req_data,
   output logic                        req_full,
   // result side
   input  wire logic                   rsp_pop,
   output rsp_type                     rsp_data,
   output logic                        rsp_empty,
   // register writes
   input  wire logic                   csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   job_type front_job, back_job;
   logic    front_push, queue_full, queue_empty, back_pop;

   // Register file. Writes to indexes past the list are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_FORMAT_MODE:    cfg_in.format_mode     = csr_wdata[1:0];
            CSR_LEVEL_SIZE:     cfg_in.level_size_log2 = csr_wdata[3:0];
            CSR_CHANNEL_WIDTHS: cfg_in.channel_widths  = csr_wdata[15:0];
            CSR_CHANNEL_SHIFTS: cfg_in.channel_shifts  = csr_wdata[19:0];
            CSR_BITS_PER_PIXEL: cfg_in.bits_per_pixel  = csr_wdata[5:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.format_mode     <= RST_FORMAT_MODE;
         cfg_ff.level_size_log2 <= RST_LEVEL_SIZE;
         cfg_ff.channel_widths  <= RST_CHANNEL_WIDTHS;
         cfg_ff.channel_shifts  <= RST_CHANNEL_SHIFTS;
         cfg_ff.bits_per_pixel  <= RST_BITS_PER_PIXEL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: position tracking, keep decision and format conversion.
   // A request that is dropped (or yields zero bytes) never enters the queue.
   tdfc_front #(
      .SOURCE_SIDE (SOURCE_SIDE)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .job_full (queue_full),
      .job_push (front_push),
      .job      (front_job)
   );

   // Pixel queue decouples the request rate from the byte rate.
   tdfc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_job),
      .full      (queue_full),
      .pop       (back_pop),
      .pop_data  (back_job),
      .empty     (queue_empty)
   );

   // Back: byte serializer with a registered output slot.
   tdfc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (queue_empty),
      .job       (back_job),
      .job_pop   (back_pop),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .rsp_empty (rsp_empty)
   );

endmodule

`default_nettype wire
